### sv/modbus_rtu_poll_master_macros.svh
// Assertion helpers shared by the checker
`ifndef MODBUS_RTU_POLL_MASTER_MACROS_SVH
`define MODBUS_RTU_POLL_MASTER_MACROS_SVH
// Implication checked on every clock edge outside reset
`define MRPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define MRPM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### sv/mrpm_pkg.sv
package mrpm_pkg;
	localparam int RxBufferBytesDef = 16;
	localparam int MaxSlotsDef = 4;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_RXBYTE = 2'd1;
	localparam logic [1:0] ACT_TXSLOT = 2'd2;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_VALUE = 3'd1;
	localparam logic [2:0] ST_SHORT = 3'd2;
	localparam logic [2:0] ST_CRCBAD = 3'd3;
	localparam logic [2:0] ST_OTHER = 3'd4;
	localparam logic [2:0] ST_TIMEOUT = 3'd5;

	localparam logic [2:0] CFG_STATION = 3'd0;
	localparam logic [2:0] CFG_SLOTS = 3'd1;
	localparam logic [2:0] CFG_REG0 = 3'd2;
	localparam logic [2:0] CFG_REG1 = 3'd3;
	localparam logic [2:0] CFG_REG2 = 3'd4;
	localparam logic [2:0] CFG_REG3 = 3'd5;
	localparam logic [2:0] CFG_TIMEOUT = 3'd6;
	localparam logic [2:0] CFG_GAP = 3'd7;

	localparam logic [15:0] REG_BASE = 16'd40001;
	localparam logic [15:0] REG_SCALED = 16'd40003;
	localparam logic [15:0] SCALE_MUL = 16'd19207;
	localparam logic [7:0] NOREPLY_GAP = 8'd8;
	localparam logic [7:0] FUNC_READ = 8'h03;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_data;
		logic line_idle;
	} in_item_t;

	typedef struct packed {
		logic tx_valid;
		logic [7:0] tx_data;
		logic driver_enable;
		logic value_valid;
		logic [1:0] value_slot;
		logic [15:0] value_data;
		logic [2:0] frame_status;
	} out_item_t;

	// Front-to-back command
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_data;
		logic line_idle;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_TX = 3'b010,
		PH_RX = 3'b100
	} phase_t;

	// One byte of the Modbus CRC-16, bit-parallel
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction
endpackage

### sv/mrpm_front.sv
module mrpm_front import mrpm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input in_item_t in_item,
	input logic in_valid,
	output logic in_stall,
	output cmd_t q_cmd,
	output logic q_valid,
	input logic q_pop
);
	// Two-entry queue; every event, action 3 included, takes a slot
	cmd_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rd_q];

	// Hold the entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cmd_t'(in_item);
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### sv/mrpm_back.sv
module mrpm_back import mrpm_pkg::*; #(
	parameter int RX_BUFFER_BYTES = RxBufferBytesDef,
	parameter int MAX_SLOTS = MaxSlotsDef
) (
	input logic clk,
	input logic arst_n,
	input cmd_t q_cmd,
	input logic q_valid,
	output logic q_pop,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	output out_item_t out_item,
	output logic out_valid,
	input logic out_stall
);
	localparam int CW = $clog2(RX_BUFFER_BYTES + 1);

	logic [7:0] station_q, timeout_q, gap_q;
	logic [2:0] slots_q;
	logic [15:0] reg_q [4];

	phase_t phase_q;
	logic [7:0] gap_count_q, reply_count_q;
	logic [1:0] slot_q;
	logic [3:0] pos_q;
	logic [15:0] send_crc_q, rx_crc_q;
	logic [CW-1:0] rx_count_q;
	logic [7:0] last_q;
	logic [7:0] hdr_q [4];
	logic drv_q;

	// Scaling stage for the 40003 reading
	logic sc_pend_q;
	logic [31:0] sc_prod_q;

	logic ov_q;
	out_item_t ob_q;

	assign cfg_ready = 1'b1;

	logic out_free, adv;
	assign out_free = !ov_q || !out_stall;
	assign adv = out_free && !sc_pend_q;
	assign q_pop = q_valid && adv;
	assign out_valid = ov_q;
	assign out_item = ob_q;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'd17;
			slots_q <= 3'd4;
			reg_q[0] <= 16'd40003;
			reg_q[1] <= 16'd40015;
			reg_q[2] <= 16'd40024;
			reg_q[3] <= 16'd40025;
			timeout_q <= 8'd20;
			gap_q <= 8'd208;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STATION: station_q <= cfg_data[7:0];
				CFG_SLOTS: slots_q <= cfg_data[2:0];
				CFG_REG0: reg_q[0] <= cfg_data;
				CFG_REG1: reg_q[1] <= cfg_data;
				CFG_REG2: reg_q[2] <= cfg_data;
				CFG_REG3: reg_q[3] <= cfg_data;
				CFG_TIMEOUT: timeout_q <= cfg_data[7:0];
				CFG_GAP: gap_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Request byte and frame check
	logic [15:0] off, cur_reg;
	logic [7:0] req_byte;
	logic [2:0] cnt_lim;
	logic [2:0] nx_slot;
	logic [15:0] full_crc;
	logic [7:0] reply_dec;

	always_comb begin
		cur_reg = reg_q[slot_q];
		off = cur_reg - REG_BASE;
		case (pos_q)
			4'd0: req_byte = station_q;
			4'd1: req_byte = FUNC_READ;
			4'd2: req_byte = off[15:8];
			4'd3: req_byte = off[7:0];
			4'd4: req_byte = 8'd0;
			4'd5: req_byte = 8'd1;
			4'd6: req_byte = send_crc_q[7:0];
			default: req_byte = send_crc_q[15:8];
		endcase
		cnt_lim = (slots_q > 3'(MAX_SLOTS)) ? 3'(MAX_SLOTS) : slots_q;
		nx_slot = {1'b0, slot_q} + 3'd1;
		full_crc = crc_byte(rx_crc_q, last_q);
		reply_dec = reply_count_q - 8'd1;
	end

	// Advance the state on each command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			gap_count_q <= 8'd0;
			reply_count_q <= 8'd0;
			slot_q <= 2'd0;
			pos_q <= 4'd0;
			send_crc_q <= 16'hFFFF;
			rx_count_q <= '0;
			rx_crc_q <= 16'hFFFF;
			last_q <= 8'd0;
			drv_q <= 1'b0;
			ov_q <= 1'b0;
			sc_pend_q <= 1'b0;
		end else begin
			if (out_free) ov_q <= 1'b0;
			if (sc_pend_q && out_free) begin
				sc_pend_q <= 1'b0;
				ov_q <= 1'b1;
			end
			if (q_pop) begin
				ov_q <= 1'b1;
				case (q_cmd.action)
					ACT_TICK: begin
						if (phase_q == PH_IDLE) begin
							if (gap_count_q != 8'd0) gap_count_q <= gap_count_q - 8'd1;
							else begin
								slot_q <= (nx_slot >= cnt_lim) ? 2'd0 : nx_slot[1:0];
								phase_q <= PH_TX;
								pos_q <= 4'd0;
								send_crc_q <= 16'hFFFF;
								drv_q <= 1'b1;
							end
						end else if (phase_q == PH_RX) begin
							reply_count_q <= reply_dec;
							if (reply_dec == 8'd0) begin
								gap_count_q <= NOREPLY_GAP;
								phase_q <= PH_IDLE;
							end else if (rx_count_q != '0 && q_cmd.line_idle) begin
								if (rx_count_q >= CW'(4) && full_crc == 16'd0
										&& hdr_q[0] == FUNC_READ && rx_count_q == CW'(7)
										&& hdr_q[1] == 8'd2 && cur_reg == REG_SCALED) begin
									ov_q <= 1'b0;
									sc_pend_q <= 1'b1;
								end
								rx_count_q <= '0;
								rx_crc_q <= 16'hFFFF;
								last_q <= 8'd0;
								gap_count_q <= gap_q;
								phase_q <= PH_IDLE;
							end
						end
					end
					ACT_RXBYTE: begin
						last_q <= q_cmd.rx_data;
						if (rx_count_q < CW'(RX_BUFFER_BYTES)) begin
							if (rx_count_q != '0) rx_crc_q <= full_crc;
							rx_count_q <= rx_count_q + CW'(1);
						end
					end
					ACT_TXSLOT: begin
						if (phase_q == PH_TX) begin
							if (pos_q < 4'd8) begin
								if (pos_q < 4'd6) send_crc_q <= crc_byte(send_crc_q, req_byte);
								pos_q <= pos_q + 4'd1;
							end else begin
								drv_q <= 1'b0;
								rx_count_q <= '0;
								rx_crc_q <= 16'hFFFF;
								last_q <= 8'd0;
								phase_q <= PH_RX;
								reply_count_q <= timeout_q;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Header bytes, product and result payload
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.action == ACT_RXBYTE && rx_count_q >= CW'(1)
				&& rx_count_q <= CW'(4))
			hdr_q[2'(rx_count_q - CW'(1))] <= q_cmd.rx_data;
		if (sc_pend_q && out_free)
			ob_q.value_data <= sc_prod_q[31:16];
		if (q_pop) begin
			sc_prod_q <= {hdr_q[2], hdr_q[3]} * SCALE_MUL;
			ob_q.tx_valid <= 1'b0;
			ob_q.tx_data <= 8'd0;
			ob_q.value_valid <= 1'b0;
			ob_q.value_slot <= 2'd0;
			ob_q.value_data <= 16'd0;
			ob_q.frame_status <= ST_NONE;
			ob_q.driver_enable <= drv_q;
			case (q_cmd.action)
				ACT_TICK: begin
					if (phase_q == PH_IDLE && gap_count_q == 8'd0)
						ob_q.driver_enable <= 1'b1;
					else if (phase_q == PH_RX) begin
						if (reply_dec == 8'd0) ob_q.frame_status <= ST_TIMEOUT;
						else if (rx_count_q != '0 && q_cmd.line_idle) begin
							if (rx_count_q < CW'(4)) ob_q.frame_status <= ST_SHORT;
							else if (full_crc != 16'd0) ob_q.frame_status <= ST_CRCBAD;
							else if (hdr_q[0] == FUNC_READ && rx_count_q == CW'(7)
									&& hdr_q[1] == 8'd2) begin
								ob_q.value_valid <= 1'b1;
								ob_q.value_slot <= slot_q;
								ob_q.value_data <= {hdr_q[2], hdr_q[3]};
								ob_q.frame_status <= ST_VALUE;
							end else ob_q.frame_status <= ST_OTHER;
						end
					end
				end
				ACT_TXSLOT: begin
					if (phase_q == PH_TX) begin
						if (pos_q < 4'd8) begin
							ob_q.tx_valid <= 1'b1;
							ob_q.tx_data <= req_byte;
						end else ob_q.driver_enable <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### sv/modbus_rtu_poll_master.sv
// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_stall  | action, rx_data, line_idle
// out      | output    | out_valid/out_stall| tx and value fields, frame_status
// cfg      | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// One event per cycle while in_stall is low; each accepted event passes through a
// two-entry queue and an output register. A good reading of register 40003
// is held in the back end for the scaling multiply before it is shown.
// arst_n clears control state and loads register defaults.
// A stalled output holds the back end; the queue keeps the input moving until it is full.
module modbus_rtu_poll_master import mrpm_pkg::*; #(
	parameter int RX_BUFFER_BYTES = RxBufferBytesDef,
	parameter int MAX_SLOTS = MaxSlotsDef
) (
	input logic clk,
	input logic arst_n,
	input in_item_t in_item,
	input logic in_valid,
	output logic in_stall,
	output out_item_t out_item,
	output logic out_valid,
	input logic out_stall,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	cmd_t q_cmd;
	logic q_valid, q_pop;

	mrpm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .in_valid(in_valid),
		.in_stall(in_stall), .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop)
	);

	mrpm_back #(.RX_BUFFER_BYTES(RX_BUFFER_BYTES), .MAX_SLOTS(MAX_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .out_item(out_item), .out_valid(out_valid),
		.out_stall(out_stall)
	);
endmodule

### sv/mrpm_checker.sv
`include "modbus_rtu_poll_master_macros.svh"
module mrpm_checker import mrpm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_item
);
	// Stalled result holds
	`MRPM_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	// Reading only with value status
	`MRPM_ASSERT_IMP(a_val, clk, arst_n, out_valid && out_item.value_valid, out_item.frame_status == ST_VALUE)
	// A sent byte keeps the driver on
	`MRPM_ASSERT_IMP(a_drv, clk, arst_n, out_valid && out_item.tx_valid, out_item.driver_enable)
	// Status never beyond timeout
	`MRPM_ASSERT_IMP(a_st, clk, arst_n, out_valid, out_item.frame_status <= ST_TIMEOUT)
endmodule

bind modbus_rtu_poll_master mrpm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_stall(out_stall), .out_item(out_item)
);
